// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file qte_checker.sv.
// Uses the clk and rst names of the scope that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define QTE_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define QTE_CHECK_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/qte_pkg.sv -----
// Shared widths, types, constants and helper functions of the quaternion
// to Euler angle converter. No dependencies.
package qte_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int MAG_W = 34;
  localparam int NORM_W = 41;
  localparam int CORD_W = 45;
  localparam int CORDIC_STEPS = 30;
  localparam int NORM_STEPS = 6;
  localparam int ISQRT_STEPS = 32;
  localparam int PITCH_LAT = 3 + ISQRT_STEPS;
  localparam logic [29:0] RAD_TO_DEG_Q24 = 30'd961263669;

  typedef struct packed {
    logic signed [32:0] yaw_x;
    logic signed [33:0] yaw_y;
    logic signed [32:0] roll_x;
    logic signed [33:0] roll_y;
    logic signed [33:0] p_num;
    logic [32:0]        p_den;
  } front_t;

  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic             x_neg;
    logic             y_neg;
    logic             f_zero;
    logic             f_right;
  } atan_in_t;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic zero;
    logic right;
  } atan_flag_t;

  typedef struct packed {
    logic [30:0] an;
    logic        neg;
    logic        pz;
    logic        pr;
  } pitch_side_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  // atan(2^-i), Q30 radians
  function automatic logic signed [31:0] atan_step(input int i);
    logic signed [31:0] t;
    case (i)
      0:  t = 32'sd843314857;
      1:  t = 32'sd497837829;
      2:  t = 32'sd263043837;
      3:  t = 32'sd133525159;
      4:  t = 32'sd67021687;
      5:  t = 32'sd33543516;
      6:  t = 32'sd16775851;
      7:  t = 32'sd8388437;
      8:  t = 32'sd4194283;
      9:  t = 32'sd2097149;
      default: t = 32'sd1 <<< (30 - i);
    endcase
    atan_step = t;
  endfunction

endpackage

// ----- src/qte_if.sv -----
// Valid/ready channel interfaces for quaternion input and Euler output.
// Depends on nothing.
interface qte_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] q_real;
  logic signed [15:0] q_i;
  logic signed [15:0] q_j;
  logic signed [15:0] q_k;
  modport source (output valid, q_real, q_i, q_j, q_k, input ready);
  modport sink (input valid, q_real, q_i, q_j, q_k, output ready);
endinterface

interface qte_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_deg;
  logic signed [14:0] pitch_deg;
  logic signed [15:0] roll_deg;
  modport source (output valid, yaw_deg, pitch_deg, roll_deg, input ready);
  modport sink (input valid, yaw_deg, pitch_deg, roll_deg, output ready);
endinterface

// ----- src/quaternion_to_euler_angles.sv -----
// Channel  | Dir | Payload
// quat     | in  | q_real, q_i, q_j, q_k (signed Q2.14)
// euler    | out | yaw_deg (negated yaw), pitch_deg, roll_deg (deg * 2^ANGLE_FRAC_BITS)
//
// One transfer per cycle in, one per cycle out while euler is not stalled; the
// pitch path runs through the 32-step square root and the 30-step CORDIC stages.
// Synchronous reset clears all valid bits. A stall on euler holds the whole
// pipeline; quat.ready is low only while a result waits and euler.ready is low.
// Depends on qte_pkg, qte_if, qte_front, qte_pitch, qte_atan.
module quaternion_to_euler_angles #(
  parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS,
  localparam int ANG_W = ANGLE_FRAC_BITS + 9
) (
  input logic             clk,
  input logic             rst,
  qte_quat_if.sink        quat,
  qte_euler_if.source     euler
);

  localparam int DL = qte_pkg::PITCH_LAT;

  logic              en;
  logic              f_valid;
  qte_pkg::front_t   f_data;
  qte_pkg::atan_in_t yaw_in, roll_in, pitch_in;
  qte_pkg::atan_in_t yaw_dl [0:DL-1];
  qte_pkg::atan_in_t roll_dl [0:DL-1];
  logic              p_valid;
  logic              yaw_v, pitch_v, roll_v;
  logic signed [ANG_W-1:0] yaw_a, pitch_a, roll_a, yaw_n;

  assign en         = !euler.valid || euler.ready;
  assign quat.ready = en;

  qte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (quat.valid),
    .q_real    (quat.q_real),
    .q_i       (quat.q_i),
    .q_j       (quat.q_j),
    .q_k       (quat.q_k),
    .out_valid (f_valid),
    .out_data  (f_data)
  );

  qte_pitch u_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       (f_data.p_num),
    .den       (f_data.p_den),
    .out_valid (p_valid),
    .out_data  (pitch_in)
  );

  always_comb begin
    yaw_in.ax      = qte_pkg::mag(34'(f_data.yaw_x));
    yaw_in.ay      = qte_pkg::mag(f_data.yaw_y);
    yaw_in.x_neg   = f_data.yaw_x[32];
    yaw_in.y_neg   = f_data.yaw_y[33];
    yaw_in.f_zero  = 1'b0;
    yaw_in.f_right = 1'b0;
    roll_in.ax      = qte_pkg::mag(34'(f_data.roll_x));
    roll_in.ay      = qte_pkg::mag(f_data.roll_y);
    roll_in.x_neg   = f_data.roll_x[32];
    roll_in.y_neg   = f_data.roll_y[33];
    roll_in.f_zero  = 1'b0;
    roll_in.f_right = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_dl[0]  <= yaw_in;
      roll_dl[0] <= roll_in;
      for (int i = 1; i < DL; i++) begin
        yaw_dl[i]  <= yaw_dl[i-1];
        roll_dl[i] <= roll_dl[i-1];
      end
    end
  end

  qte_atan #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_valid),
    .in_data(yaw_dl[DL-1]), .out_valid(yaw_v), .angle(yaw_a)
  );

  qte_atan #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch_atan (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_valid),
    .in_data(pitch_in), .out_valid(pitch_v), .angle(pitch_a)
  );

  qte_atan #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_valid),
    .in_data(roll_dl[DL-1]), .out_valid(roll_v), .angle(roll_a)
  );

  assign yaw_n = -yaw_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      euler.valid <= 1'b0;
    end else if (en) begin
      euler.valid <= yaw_v && pitch_v && roll_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      euler.yaw_deg   <= 16'(yaw_n);
      euler.pitch_deg <= 15'(pitch_a);
      euler.roll_deg  <= 16'(roll_a);
    end
  end

endmodule

// ----- src/qte_front.sv -----
// Front end: quaternion products, then the atan2 and asin operands.
// Depends on qte_pkg.
module qte_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] q_real,
  input  logic signed [15:0] q_i,
  input  logic signed [15:0] q_j,
  input  logic signed [15:0] q_k,
  output logic               out_valid,
  output qte_pkg::front_t    out_data
);

  logic               valid1;
  logic signed [31:0] rr, ii, jj, kk, ij, kr, ik, jr, jk, ir;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid1    <= in_valid;
      out_valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr <= q_real * q_real;
      ii <= q_i * q_i;
      jj <= q_j * q_j;
      kk <= q_k * q_k;
      ij <= q_i * q_j;
      kr <= q_k * q_real;
      ik <= q_i * q_k;
      jr <= q_j * q_real;
      jk <= q_j * q_k;
      ir <= q_i * q_real;
      out_data.yaw_x  <= 33'(ii) - 33'(jj) - 33'(kk) + 33'(rr);
      out_data.yaw_y  <= (34'(ij) + 34'(kr)) <<< 1;
      out_data.roll_x <= 33'(kk) + 33'(rr) - 33'(ii) - 33'(jj);
      out_data.roll_y <= (34'(jk) + 34'(ir)) <<< 1;
      out_data.p_num  <= (34'(jr) - 34'(ik)) <<< 1;
      out_data.p_den  <= 33'(unsigned'(rr)) + 33'(unsigned'(ii))
                       + 33'(unsigned'(jj)) + 33'(unsigned'(kk));
    end
  end

endmodule

// ----- src/qte_pitch.sv -----
// Pitch operand path: saturation tests, scaling, squares and a pipelined
// integer square root of den^2 - num^2. Depends on qte_pkg.
module qte_pitch (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [33:0]  num,
  input  logic [32:0]         den,
  output logic                out_valid,
  output qte_pkg::atan_in_t   out_data
);

  localparam int N = qte_pkg::ISQRT_STEPS;

  logic [33:0]          an_full;
  logic                 pz_c, pr_c;
  logic [32:0]          d_sh;
  logic [33:0]          a_sh;

  logic                 v1, v2;
  logic [30:0]          d1, a1;
  qte_pkg::pitch_side_t s1, s2;
  logic [61:0]          dd, aa;

  logic [63:0]          sv [0:N];
  logic [63:0]          sr [0:N];
  qte_pkg::pitch_side_t ss [0:N];
  logic                 vv [0:N];

  always_comb begin
    an_full = qte_pkg::mag(num);
    pz_c    = (den == '0) || (an_full == '0);
    pr_c    = !pz_c && ({1'b0, den} <= an_full);
    if (den[32]) begin
      d_sh = den >> 2;
      a_sh = an_full >> 2;
    end else if (den[31]) begin
      d_sh = den >> 1;
      a_sh = an_full >> 1;
    end else begin
      d_sh = den;
      a_sh = an_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      vv[0] <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      vv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1     <= d_sh[30:0];
      a1     <= a_sh[30:0];
      s1.an  <= a_sh[30:0];
      s1.neg <= num[33];
      s1.pz  <= pz_c;
      s1.pr  <= pr_c;
      dd     <= d1 * d1;
      aa     <= a1 * a1;
      s2     <= s1;
      sv[0]  <= {2'b00, dd - aa};
      sr[0]  <= '0;
      ss[0]  <= s2;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = sr[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k+1] <= 1'b0;
      end else if (en) begin
        vv[k+1] <= vv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (sv[k] >= trial) begin
          sv[k+1] <= sv[k] - trial;
          sr[k+1] <= (sr[k] >> 1) + BIT;
        end else begin
          sv[k+1] <= sv[k];
          sr[k+1] <= sr[k] >> 1;
        end
        ss[k+1] <= ss[k];
      end
    end
  end

  assign out_valid        = vv[N];
  assign out_data.ax      = qte_pkg::MAG_W'(sr[N][30:0]);
  assign out_data.ay      = qte_pkg::MAG_W'(ss[N].an);
  assign out_data.x_neg   = 1'b0;
  assign out_data.y_neg   = ss[N].neg;
  assign out_data.f_zero  = ss[N].pz;
  assign out_data.f_right = ss[N].pr;

endmodule

// ----- src/qte_atan.sv -----
// Pipelined atan2: normalizing shift, vectoring CORDIC, scaling to
// degrees, clamp and quadrant fix. Depends on qte_pkg.
module qte_atan #(
  parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS,
  localparam int ANG_W = ANGLE_FRAC_BITS + 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  qte_pkg::atan_in_t       in_data,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] angle
);

  localparam int NW = qte_pkg::NORM_W;
  localparam int CW = qte_pkg::CORD_W;
  localparam int NS = qte_pkg::NORM_STEPS;
  localparam int CS = qte_pkg::CORDIC_STEPS;
  localparam int S  = 54 - ANGLE_FRAC_BITS;
  localparam logic [61:0] HALF = 62'd1 << (S - 1);
  localparam logic [61:0] RIGHT = 62'd90 << ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] RIGHT_A = ANG_W'(90) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180) <<< ANGLE_FRAC_BITS;

  logic [NW-1:0]        nx [0:NS-1];
  logic [NW-1:0]        ny [0:NS-1];
  qte_pkg::atan_flag_t  nf [0:NS-1];
  logic                 nv [0:NS-1];

  logic signed [CW-1:0] cx [0:CS];
  logic signed [CW-1:0] cy [0:CS];
  logic signed [31:0]   cz [0:CS];
  qte_pkg::atan_flag_t  cf [0:CS];
  logic                 cv [0:CS];

  logic [60:0]          mp;
  qte_pkg::atan_flag_t  mf;
  logic                 mv;

  logic                 zero_c, right_c;
  logic [61:0]          rnd;
  logic signed [ANG_W-1:0] a_q, a_fix;

  assign zero_c  = in_data.f_zero || (!in_data.f_right && in_data.ay == '0);
  assign right_c = !zero_c && (in_data.f_right || in_data.ax == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      nv[0] <= 1'b0;
      mv    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      nv[0] <= in_valid;
      mv    <= cv[CS];
      out_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx[0]       <= NW'(in_data.ax);
      ny[0]       <= NW'(in_data.ay);
      nf[0].x_neg <= in_data.x_neg;
      nf[0].y_neg <= in_data.y_neg;
      nf[0].zero  <= zero_c;
      nf[0].right <= right_c;
    end
  end

  for (genvar m = 0; m < NS; m++) begin : g_norm
    localparam int SH = 32 >> m;
    logic [NW-1:0] orv, sx, sy;
    logic          sft;
    assign orv = nx[m] | ny[m];
    assign sft = (orv[NW-1 -: SH] == '0);
    assign sx  = sft ? (nx[m] << SH) : nx[m];
    assign sy  = sft ? (ny[m] << SH) : ny[m];

    if (m == NS - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (rst) begin
          cv[0] <= 1'b0;
        end else if (en) begin
          cv[0] <= nv[m];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          cx[0] <= CW'(sx);
          cy[0] <= CW'(sy);
          cz[0] <= '0;
          cf[0] <= nf[m];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (rst) begin
          nv[m+1] <= 1'b0;
        end else if (en) begin
          nv[m+1] <= nv[m];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          nx[m+1] <= sx;
          ny[m+1] <= sy;
          nf[m+1] <= nf[m];
        end
      end
    end
  end

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    localparam logic signed [31:0] T = qte_pkg::atan_step(k);
    logic signed [CW-1:0] dx, dy;
    assign dx = cy[k] >>> k;
    assign dy = cx[k] >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else if (en) begin
        cv[k+1] <= cv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[k][CW-1]) begin
          cx[k+1] <= cx[k] + dx;
          cy[k+1] <= cy[k] - dy;
          cz[k+1] <= cz[k] + T;
        end else begin
          cx[k+1] <= cx[k] - dx;
          cy[k+1] <= cy[k] + dy;
          cz[k+1] <= cz[k] - T;
        end
        cf[k+1] <= cf[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mp <= (cz[CS][31] ? 31'd0 : cz[CS][30:0]) * qte_pkg::RAD_TO_DEG_Q24;
      mf <= cf[CS];
    end
  end

  always_comb begin
    rnd = (62'(mp) + HALF) >> S;
    if (mf.zero) begin
      a_q = '0;
    end else if (mf.right || rnd > RIGHT) begin
      a_q = RIGHT_A;
    end else begin
      a_q = ANG_W'(rnd);
    end
    a_fix = mf.x_neg ? (HALF_TURN - a_q) : a_q;
    if (mf.y_neg) begin
      a_fix = -a_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= a_fix;
    end
  end

endmodule

// ----- src/qte_checker.sv -----
// Port-level checks of the converter, bound to the top level.
// Depends on assert_macros.svh and quaternion_to_euler_angles.
`include "assert_macros.svh"

module qte_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] yaw_deg,
  input logic signed [14:0] pitch_deg,
  input logic signed [15:0] roll_deg
);

  `QTE_CHECK(a_ready_rule, 1'b1 |-> (in_ready == (!out_valid || out_ready)), "input ready mismatch")
  `QTE_CHECK(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result dropped during stall")
  `QTE_CHECK(a_out_stable, (out_valid && !out_ready) |=> ($stable(yaw_deg) && $stable(pitch_deg) && $stable(roll_deg)), "result changed during stall")
  `QTE_CHECK_RST(a_reset_clear, $past(rst) |-> !out_valid, "valid after reset")

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (quat.ready),
  .out_valid (euler.valid),
  .out_ready (euler.ready),
  .yaw_deg   (euler.yaw_deg),
  .pitch_deg (euler.pitch_deg),
  .roll_deg  (euler.roll_deg)
);
